/* src/vknt_pkg.sv */
package vknt_pkg;

	// Contact event codes
	localparam logic [1:0] FUNC_START_CLOSE = 2'd0;
	localparam logic [1:0] FUNC_END_CLOSE   = 2'd1;
	localparam logic [1:0] FUNC_START_OPEN  = 2'd2;
	localparam logic [1:0] FUNC_END_OPEN    = 2'd3;

	localparam int NOTE_BASE = 36;
	localparam int NOTE_MAX  = 127;
	localparam int VEL_MAX   = 127;
	localparam int VEL_FLOOR = 16;
	// Smallest gap whose velocity lands on the floor
	localparam int GAP_SAT   = (VEL_MAX - VEL_FLOOR) / 2 + 1;

	typedef struct packed {
		logic [31:0] start_stamp;
		logic [31:0] end_stamp;
		logic        start_closed;
		logic        end_closed;
		logic        sounding;
		logic [6:0]  sounding_note;
	} entry_t;

	typedef struct packed {
		logic capture;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic has_result;
	} sts_t;

endpackage

/* src/vknt_ctrl.sv */
module vknt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  vknt_pkg::sts_t sts,
	output vknt_pkg::cmd_t cmd
);
	import vknt_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   can_commit;

	// Hold the entry while the output register still carries an untaken request
	assign can_commit = !sts.has_result || !out_valid_q || out_ready;

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
				if (in_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.commit = can_commit;
				if (can_commit) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit && sts.has_result) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* src/vknt_dp.sv */
module vknt_dp #(
	parameter int NUM_KEYS = 37
) (
	input  logic              clk,
	input  logic              arst_n,
	input  vknt_pkg::cmd_t    cmd,
	output vknt_pkg::sts_t    sts,
	input  logic              cfg_we,
	input  logic signed [6:0] cfg_data,
	input  logic [1:0]        func,
	input  logic [5:0]        key_index,
	input  logic [31:0]       time_ms,
	output logic              is_note_on,
	output logic [6:0]        note_number,
	output logic [6:0]        velocity
);
	import vknt_pkg::*;

	localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
	localparam int IW = (KW > 6) ? KW : 6;

	entry_t               mem [NUM_KEYS];
	logic [NUM_KEYS-1:0]  valid_q;
	logic signed [6:0]    octave_q;

	logic [IW-1:0]        key_w;
	logic [KW-1:0]        idx;
	logic                 key_ok;

	entry_t               rd_s1;
	logic                 rd_valid_s1;
	logic [1:0]           func_s1;
	logic [5:0]           key_s1;
	logic [KW-1:0]        idx_s1;
	logic [31:0]          time_s1;
	logic                 key_ok_s1;

	entry_t               cur;
	entry_t               nxt;
	logic                 is_close;
	logic                 note_on;
	logic                 note_stop;
	logic signed [9:0]    note_sum;
	logic [6:0]           note_new;
	logic [31:0]          other_stamp;
	logic [32:0]          diff_ab;
	logic [32:0]          diff_ba;
	logic [31:0]          gap;
	logic [6:0]           vel_new;

	logic                 is_note_on_q;
	logic [6:0]           note_q;
	logic [6:0]           vel_q;

	assign key_w  = IW'(key_index);
	assign idx    = key_w[KW-1:0];
	assign key_ok = {2'b00, key_index} < 8'(NUM_KEYS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			octave_q <= '0;
			valid_q  <= '0;
		end else begin
			if (cfg_we) begin
				octave_q <= cfg_data;
			end
			if (cmd.commit && key_ok_s1) begin
				valid_q[idx_s1] <= 1'b1;
			end
		end
	end

	// Per-key record: registered read on capture, write back on commit
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			rd_s1       <= mem[idx];
			rd_valid_s1 <= valid_q[idx] && key_ok;
			func_s1     <= func;
			key_s1      <= key_index;
			idx_s1      <= idx;
			time_s1     <= time_ms;
			key_ok_s1   <= key_ok;
		end
		if (cmd.commit && key_ok_s1) begin
			mem[idx_s1] <= nxt;
		end
	end

	// A never-written entry reads as its reset value
	assign cur = rd_valid_s1 ? rd_s1 : '0;

	assign is_close = (func_s1 == FUNC_START_CLOSE) || (func_s1 == FUNC_END_CLOSE);

	assign note_sum = $signed(10'(NOTE_BASE)) + {{3{octave_q[6]}}, octave_q}
		+ $signed({4'b0000, key_s1});

	always_comb begin
		if (note_sum < 0) begin
			note_new = '0;
		end else if (note_sum > $signed(10'(NOTE_MAX))) begin
			note_new = 7'(NOTE_MAX);
		end else begin
			note_new = note_sum[6:0];
		end
	end

	assign other_stamp = (func_s1 == FUNC_START_CLOSE) ? cur.end_stamp : cur.start_stamp;
	assign diff_ab     = {1'b0, time_s1} - {1'b0, other_stamp};
	assign diff_ba     = {1'b0, other_stamp} - {1'b0, time_s1};
	assign gap         = diff_ab[32] ? diff_ba[31:0] : diff_ab[31:0];
	assign vel_new     = (gap >= 32'(GAP_SAT)) ? 7'(VEL_FLOOR)
		: 7'(VEL_MAX) - {gap[5:0], 1'b0};

	always_comb begin
		nxt = cur;
		case (func_s1)
			FUNC_START_CLOSE: begin
				nxt.start_stamp  = time_s1;
				nxt.start_closed = 1'b1;
			end
			FUNC_END_CLOSE: begin
				nxt.end_stamp  = time_s1;
				nxt.end_closed = 1'b1;
			end
			FUNC_START_OPEN: begin
				nxt.start_closed = 1'b0;
			end
			default: begin
				nxt.end_closed = 1'b0;
			end
		endcase
		note_on   = key_ok_s1 && is_close && nxt.start_closed && nxt.end_closed
			&& !cur.sounding;
		note_stop = key_ok_s1 && !is_close && !nxt.start_closed && !nxt.end_closed
			&& cur.sounding;
		if (note_on) begin
			nxt.sounding      = 1'b1;
			nxt.sounding_note = note_new;
		end
		if (note_stop) begin
			nxt.sounding = 1'b0;
		end
	end

	assign sts.has_result = note_on || note_stop;

	always_ff @(posedge clk) begin
		if (cmd.commit && sts.has_result) begin
			is_note_on_q <= note_on;
			note_q       <= note_on ? note_new : cur.sounding_note;
			vel_q        <= note_on ? vel_new : '0;
		end
	end

	assign is_note_on  = is_note_on_q;
	assign note_number = note_q;
	assign velocity    = vel_q;

endmodule

/* src/velocity_key_note_tracker.sv */
// A note request is registered on the output when its contact event commits, after the
// registered read of the per-key record; the record is then written back, and no new event
// is taken before that commit. A full output register stalls only events that make a note.
// Reset (arst_n low, asynchronous): per-key valid bits clear, so every key reads as both
// contacts open with no note sounding; octave offset returns to 0. No clearing pass.
module velocity_key_note_tracker #(
	parameter int NUM_KEYS = 37
) (
	input  logic              clk,
	input  logic              arst_n,
	// Configuration write: octave offset
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic signed [6:0] cfg_data,
	// Contact events
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        func,
	input  logic [5:0]        key_index,
	input  logic [31:0]       time_ms,
	// Note requests
	output logic              out_valid,
	input  logic              out_ready,
	output logic              is_note_on,
	output logic [6:0]        note_number,
	output logic [6:0]        velocity
);
	import vknt_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// The offset register takes a write in any cycle
	assign cfg_ready = 1'b1;

	// Controller: sequence capture and commit, own the output valid flag
	vknt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath: per-key record memory, note and velocity arithmetic, output register
	vknt_dp #(
		.NUM_KEYS (NUM_KEYS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_data    (cfg_data),
		.func        (func),
		.key_index   (key_index),
		.time_ms     (time_ms),
		.is_note_on  (is_note_on),
		.note_number (note_number),
		.velocity    (velocity)
	);

	// An event is taken, then the block is busy for its commit cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("event accepted while previous event still in flight");

	// Note-off requests carry zero velocity
	a_off_zero_vel: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !is_note_on) |-> (velocity == 7'd0))
		else $error("note-off request with nonzero velocity");

	// Note-on velocity never drops below the floor
	a_on_vel_floor: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_note_on) |-> (velocity >= 7'(VEL_FLOOR)))
		else $error("note-on velocity below floor");

	// Two captures are never issued back to back
	a_commit_after_capture: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.capture) |=> !cmd.capture)
		else $error("capture issued twice in a row");

endmodule
